/* hw/rtl/rrtq_pkg.sv */
// Shared definitions for the round-robin task queue.
// Request codes, register indexes, field widths and the controller/datapath
// command and status bundles. No dependencies.
package rrtq_pkg;

  localparam int unsigned ID_W         = 4;
  localparam int unsigned REQ_W        = 3;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned OUT_CNT_W    = 5;
  localparam int unsigned NUM_IDS      = 1 << ID_W;

  localparam int unsigned MAX_TASKS_DEF  = 16;
  localparam int unsigned SLICE_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] SLICE_FORE_RST = 16'd100;
  localparam logic [CFG_W-1:0] SLICE_BACK_RST = 16'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_FORE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_BACK = 1'd1;

  localparam logic [REQ_W-1:0] REQ_ENQUEUE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REQUEUE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PICK     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_INTERVAL = 3'd5;

  typedef struct packed {
    logic load;
    logic rm_init;
    logic rm_step;
    logic hs_init;
    logic hs_step;
    logic put;
    logic set_err;
    logic emit;
  } rrtq_cmd_t;

  typedef struct packed {
    logic need_rm;
    logic rm_last;
    logic enq_err;
    logic want_ins;
    logic head_shift;
    logic hs_last;
    logic out_free;
  } rrtq_status_t;

endpackage

/* hw/rtl/rrtq_datapath.sv */
// Datapath of the round-robin task queue: run queue, membership bits,
// slice counters, configuration registers and the result register.
// Depends on rrtq_pkg; driven by rrtq_ctrl through rrtq_cmd_t.
module rrtq_datapath import rrtq_pkg::*; #(
  parameter int unsigned MAX_TASKS  = MAX_TASKS_DEF,
  parameter int unsigned SLICE_BITS = SLICE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [ID_W-1:0]      task_id_i,
  input  logic                 at_head_i,
  input  logic                 is_foreground_i,
  input  logic                 is_rr_policy_i,
  input  rrtq_cmd_t            cmd_i,
  output rrtq_status_t         status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 task_valid_o,
  output logic [ID_W-1:0]      task_out_o,
  output logic                 need_resched_o,
  output logic [CFG_W-1:0]     interval_out_o,
  output logic [OUT_CNT_W-1:0] queue_count_o,
  output logic                 error_o
);

  // Task ids are only ID_W bits wide, so no more than NUM_IDS tasks can be queued.
  localparam int unsigned SLOTS  = (MAX_TASKS < NUM_IDS) ? MAX_TASKS : NUM_IDS;
  localparam int unsigned QIDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);

  logic [CFG_W-1:0]      slice_fore_q, slice_back_q;
  logic [REQ_W-1:0]      req_q;
  logic [ID_W-1:0]       id_q;
  logic                  head_q, fore_q, rr_q;
  logic                  expire_q, rm_done_q, err_q, found_q;
  logic [QIDX_W-1:0]     idx_q;
  logic [CNT_W-1:0]      count_q;
  logic [SLOTS-1:0]      inq_q;
  logic [SLICE_BITS-1:0] slice_q [SLOTS];
  logic [ID_W-1:0]       queue_mem [SLOTS];
  logic                  out_valid_q;

  // Slice update for a tick, computed from the incoming item.
  logic                  in_id_ok, tick_en, tick_expire;
  logic [QIDX_W-1:0]     in_slot;
  logic [SLICE_BITS-1:0] tick_len, tick_base, tick_dec, tick_new;

  assign in_id_ok    = int'(task_id_i) < MAX_TASKS;
  assign in_slot     = task_id_i[QIDX_W-1:0];
  assign tick_len    = is_foreground_i ? SLICE_BITS'(slice_fore_q) : SLICE_BITS'(slice_back_q);
  assign tick_base   = (slice_q[in_slot] == '0) ? tick_len : slice_q[in_slot];
  assign tick_dec    = tick_base - SLICE_BITS'(1);
  assign tick_expire = (tick_dec == '0);
  assign tick_new    = tick_expire ? tick_len : tick_dec;
  assign tick_en     = cmd_i.load && (req_type_i == REQ_TICK) && in_id_ok && is_rr_policy_i;

  logic              id_ok, queued, full, is_tick, ins_head, match;
  logic [QIDX_W-1:0] slot, put_addr;
  logic [ID_W-1:0]   rd_data;

  assign id_ok    = int'(id_q) < MAX_TASKS;
  assign slot     = id_q[QIDX_W-1:0];
  assign queued   = id_ok && inq_q[slot];
  assign full     = count_q >= CNT_W'(MAX_TASKS);
  assign is_tick  = (req_q == REQ_TICK);
  assign ins_head = head_q && !is_tick;
  assign put_addr = ins_head ? '0 : count_q[QIDX_W-1:0];
  assign rd_data  = queue_mem[idx_q];
  assign match    = (rd_data == id_q);

  always_comb begin
    status_o.need_rm = queued && ((req_q == REQ_ENQUEUE) || (req_q == REQ_DEQUEUE) ||
                       (req_q == REQ_REQUEUE) ||
                       (is_tick && expire_q && (count_q >= CNT_W'(2))));
    status_o.rm_last    = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
    status_o.enq_err    = (req_q == REQ_ENQUEUE) && (!id_ok || full);
    status_o.want_ins   = ((req_q == REQ_ENQUEUE) && id_ok) ||
                          (((req_q == REQ_REQUEUE) || is_tick) && rm_done_q);
    status_o.head_shift = ins_head && (count_q != '0);
    status_o.hs_last    = (idx_q == '0);
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Queue storage: one write per cycle, read at the scan index and at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rm_step && found_q) begin
      queue_mem[idx_q - QIDX_W'(1)] <= rd_data;
    end else if (cmd_i.hs_step) begin
      queue_mem[idx_q + QIDX_W'(1)] <= rd_data;
    end else if (cmd_i.put) begin
      queue_mem[put_addr] <= id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_fore_q <= SLICE_FORE_RST;
      slice_back_q <= SLICE_BACK_RST;
      req_q        <= REQ_PICK;
      id_q         <= '0;
      head_q       <= 1'b0;
      fore_q       <= 1'b0;
      rr_q         <= 1'b0;
      expire_q     <= 1'b0;
      rm_done_q    <= 1'b0;
      err_q        <= 1'b0;
      found_q      <= 1'b0;
      idx_q        <= '0;
      count_q      <= '0;
      inq_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slice_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_SLICE_FORE) begin
          slice_fore_q <= cfg_data_i;
        end else begin
          slice_back_q <= cfg_data_i;
        end
      end
      if (cmd_i.load) begin
        req_q     <= req_type_i;
        id_q      <= task_id_i;
        head_q    <= at_head_i;
        fore_q    <= is_foreground_i;
        rr_q      <= is_rr_policy_i;
        expire_q  <= tick_en && tick_expire;
        rm_done_q <= 1'b0;
        err_q     <= 1'b0;
        if (tick_en) begin
          slice_q[in_slot] <= tick_new;
        end
      end
      if (cmd_i.rm_init) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      // Removal walks the queue once; after the match each entry moves down one place.
      if (cmd_i.rm_step) begin
        found_q <= found_q | match;
        idx_q   <= idx_q + QIDX_W'(1);
        if (status_o.rm_last) begin
          count_q     <= count_q - CNT_W'(1);
          inq_q[slot] <= 1'b0;
          rm_done_q   <= 1'b1;
        end
      end
      if (cmd_i.hs_init) begin
        idx_q <= count_q[QIDX_W-1:0] - QIDX_W'(1);
      end
      if (cmd_i.hs_step) begin
        idx_q <= idx_q - QIDX_W'(1);
      end
      if (cmd_i.put) begin
        count_q     <= count_q + CNT_W'(1);
        inq_q[slot] <= 1'b1;
      end
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      task_valid_o   <= (req_q == REQ_PICK) && (count_q != '0);
      task_out_o     <= ((req_q == REQ_PICK) && (count_q != '0)) ? queue_mem[0] : '0;
      need_resched_o <= is_tick && rm_done_q;
      interval_out_o <= ((req_q == REQ_INTERVAL) && rr_q) ?
                        (fore_q ? slice_fore_q : slice_back_q) : '0;
      queue_count_o  <= OUT_CNT_W'(count_q);
      error_o        <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/rrtq_ctrl.sv */
// Controller of the round-robin task queue: sequences removal, head shift,
// insertion and result hand-off. Depends on rrtq_pkg; drives rrtq_datapath.
module rrtq_ctrl import rrtq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  rrtq_status_t status_i,
  output rrtq_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RM     = 3'd2;
  localparam logic [2:0] S_INS    = 3'd3;
  localparam logic [2:0] S_HS     = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.need_rm) begin
          cmd_o.rm_init = 1'b1;
          state_d       = S_RM;
        end else begin
          state_d = S_INS;
        end
      end
      S_RM: begin
        cmd_o.rm_step = 1'b1;
        if (status_i.rm_last) begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (status_i.enq_err) begin
          cmd_o.set_err = 1'b1;
          state_d       = S_FIN;
        end else if (status_i.want_ins && status_i.head_shift) begin
          cmd_o.hs_init = 1'b1;
          state_d       = S_HS;
        end else if (status_i.want_ins) begin
          cmd_o.put = 1'b1;
          state_d   = S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_HS: begin
        cmd_o.hs_step = 1'b1;
        if (status_i.hs_last) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/round_robin_task_queue.sv */
// Round-robin run queue with per-task time slices and a result register on the output side.
// Each item is loaded and decided on; a queued task that must go is removed by a walk of the
// whole queue; an insert at the head of a non-empty queue shifts every entry up one place
// before the id is written; the result is then handed off once the output register is free.
// The serial queue walk sets the time per item. A new item is taken while the previous result
// still waits in the output register. Configuration writes are always ready.
module round_robin_task_queue import rrtq_pkg::*; #(
  parameter int unsigned MAX_TASKS  = MAX_TASKS_DEF,
  parameter int unsigned SLICE_BITS = SLICE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [ID_W-1:0]      task_id_i,
  input  logic                 at_head_i,
  input  logic                 is_foreground_i,
  input  logic                 is_rr_policy_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 task_valid_o,
  output logic [ID_W-1:0]      task_out_o,
  output logic                 need_resched_o,
  output logic [CFG_W-1:0]     interval_out_o,
  output logic [OUT_CNT_W-1:0] queue_count_o,
  output logic                 error_o
);

  rrtq_cmd_t    cmd;
  rrtq_status_t status;

  assign cfg_ready_o = 1'b1;

  rrtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrtq_datapath #(
    .MAX_TASKS  (MAX_TASKS),
    .SLICE_BITS (SLICE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .task_id_i       (task_id_i),
    .at_head_i       (at_head_i),
    .is_foreground_i (is_foreground_i),
    .is_rr_policy_i  (is_rr_policy_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .task_valid_o    (task_valid_o),
    .task_out_o      (task_out_o),
    .need_resched_o  (need_resched_o),
    .interval_out_o  (interval_out_o),
    .queue_count_o   (queue_count_o),
    .error_o         (error_o)
  );

endmodule

/* bench/round_robin_task_queue_tb.sv */
// Self-checking testbench for the round-robin task queue with time slices.
// Drives random and directed requests, predicts every result in a behavioral
// model of the run queue, and checks results in order. Depends on rrtq_pkg and round_robin_task_queue.
module round_robin_task_queue_tb;
  import rrtq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTASK = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic             task_valid;
    logic [ID_W-1:0]  task_out;
    logic             need_resched;
    logic [CFG_W-1:0] interval;
    logic [4:0]       count;
    logic             error;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [REQ_W-1:0] req_type_i = '0;
  logic [ID_W-1:0] task_id_i = '0;
  logic at_head_i = 1'b0;
  logic is_foreground_i = 1'b0;
  logic is_rr_policy_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic task_valid_o;
  logic [ID_W-1:0] task_out_o;
  logic need_resched_o;
  logic [CFG_W-1:0] interval_out_o;
  logic [OUT_CNT_W-1:0] queue_count_o;
  logic error_o;

  round_robin_task_queue dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state.
  logic [CFG_W-1:0] fore_len, back_len;
  logic [ID_W-1:0] run_order[$];
  logic [CFG_W-1:0] slice_left[NTASK];
  sched_result_t pending_results[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;

  function automatic bit is_queued(logic [ID_W-1:0] id);
    foreach (run_order[i]) if (run_order[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_task(logic [ID_W-1:0] id);
    foreach (run_order[i]) if (run_order[i] == id) begin
      run_order.delete(i);
      return;
    end
  endfunction

  function automatic sched_result_t schedule(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                             logic head, logic fg, logic rr);
    sched_result_t r;
    logic [CFG_W-1:0] len;
    r = '0;
    len = fg ? fore_len : back_len;
    case (req)
      REQ_ENQUEUE: begin
        drop_task(id);
        if (run_order.size() >= NTASK) r.error = 1'b1;
        else if (head) run_order.push_front(id);
        else run_order.push_back(id);
      end
      REQ_DEQUEUE: drop_task(id);
      REQ_REQUEUE: if (is_queued(id)) begin
        drop_task(id);
        if (head) run_order.push_front(id);
        else run_order.push_back(id);
      end
      REQ_PICK: if (run_order.size() > 0) begin
        r.task_valid = 1'b1;
        r.task_out = run_order[0];
      end
      REQ_TICK: if (rr) begin
        if (slice_left[id] == 0) slice_left[id] = len;
        slice_left[id] = slice_left[id] - 1'b1;
        if (slice_left[id] == 0) begin
          slice_left[id] = len;
          if (is_queued(id) && run_order.size() >= 2) begin
            drop_task(id);
            run_order.push_back(id);
            r.need_resched = 1'b1;
          end
        end
      end
      REQ_INTERVAL: r.interval = rr ? len : '0;
      default: ;
    endcase
    r.count = 5'(run_order.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("round_robin_task_queue_tb failed");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold when requested.
  always @(posedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    sched_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{task_valid_o, task_out_o, need_resched_o, interval_out_o,
              queue_count_o, error_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Valid stays high after the last item is taken until the next item or a drain
  // replaces it in the same time step.
  task automatic send_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                          logic head, logic fg, logic rr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    task_id_i <= id;
    at_head_i <= head;
    is_foreground_i <= fg;
    is_rr_policy_i <= rr;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(schedule(req, id, head, fg, rr));
  endtask

  task automatic send_random();
    int pick;
    logic [REQ_W-1:0] req;
    pick = $urandom_range(99);
    if (pick < 30) req = REQ_ENQUEUE;
    else if (pick < 40) req = REQ_DEQUEUE;
    else if (pick < 50) req = REQ_REQUEUE;
    else if (pick < 60) req = REQ_PICK;
    else if (pick < 90) req = REQ_TICK;
    else if (pick < 97) req = REQ_INTERVAL;
    else req = REQ_W'($urandom_range(7, 6));
    send_req(req, ID_W'($urandom_range(15)), 1'($urandom_range(1)), 1'($urandom_range(1)),
             $urandom_range(9) != 0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SLICE_FORE) fore_len = val;
    else back_len = val;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_req(REQ_PICK, 0, 0, 0, 0);
    send_req(REQ_DEQUEUE, 3, 0, 0, 0);
    send_req(REQ_REQUEUE, 3, 1, 0, 0);
    send_req(REQ_INTERVAL, 0, 0, 1, 1);
    send_req(REQ_INTERVAL, 0, 0, 0, 1);
    send_req(REQ_INTERVAL, 0, 0, 1, 0);
    send_req(REQ_ENQUEUE, 15, 0, 0, 0);
    send_req(REQ_ENQUEUE, 0, 1, 0, 0);
    send_req(REQ_ENQUEUE, 15, 1, 0, 0);
    send_req(REQ_PICK, 0, 0, 0, 0);
    send_req(REQ_REQUEUE, 15, 0, 0, 0);
    send_req(REQ_TICK, 7, 0, 0, 1);
    send_req(REQ_TICK, 0, 0, 1, 0);
    send_req(REQ_W'(6), 0, 0, 0, 0);
    send_req(REQ_W'(7), 15, 1, 1, 1);
    send_req(REQ_DEQUEUE, 0, 0, 0, 0);
    // A lone task reloads its slice without a reschedule.
    repeat (10) send_req(REQ_TICK, 15, 0, 0, 1);
    drain();
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < NTASK; i++) send_req(REQ_ENQUEUE, ID_W'(i), i[0], 0, 0);
    send_req(REQ_ENQUEUE, 5, 1, 0, 0);
    send_req(REQ_PICK, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_slice_expiry();
    write_reg(CFG_SLICE_BACK, 16'd1);
    write_reg(CFG_SLICE_FORE, 16'd2);
    for (int i = 0; i < 20; i++) send_req(REQ_TICK, ID_W'($urandom_range(15)), 0, i[0], 1);
    send_req(REQ_PICK, 0, 0, 0, 0);
    drain();
    // A zero slice wraps to all ones and does not expire.
    write_reg(CFG_SLICE_FORE, 16'd0);
    write_reg(CFG_SLICE_BACK, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_req(REQ_TICK, 2, 0, 1, 1);
    send_req(REQ_INTERVAL, 0, 0, 1, 1);
    send_req(REQ_INTERVAL, 0, 0, 0, 1);
    drain();
  endtask

  task automatic test_random(int count);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 19 : 0;
      write_reg(CFG_SLICE_FORE, CFG_W'($urandom_range(6, 1)));
      write_reg(CFG_SLICE_BACK, CFG_W'($urandom_range(4, 1)));
      repeat (count / 3) send_random();
      drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      repeat (40) send_random();
    join
    drain();
    // Sender pauses until every result has come before resuming.
    repeat (20) send_random();
    drain();
  endtask

  initial begin
    fore_len = SLICE_FORE_RST;
    back_len = SLICE_BACK_RST;
    foreach (slice_left[i]) slice_left[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_queue();
    test_slice_expiry();
    test_random(540);
    test_backpressure();
    if (errors == 0) begin
      $display("round_robin_task_queue_tb passed");
    end else begin
      $display("round_robin_task_queue_tb failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/rrtq_pkg.sv
hw/rtl/rrtq_datapath.sv
hw/rtl/rrtq_ctrl.sv
hw/rtl/round_robin_task_queue.sv
bench/round_robin_task_queue_tb.sv
